// ===== sv/ufe_pkg.sv =====
`default_nettype none

package ufe_pkg;

    // Default ring depth. One slot of the ring is never used, so a ring holds
    // one entry fewer than its depth.
    localparam int RING_DEPTH_DEF = 16;

    localparam int DATA_W  = 8;
    localparam int FLAGS_W = 3;
    localparam int COUNT_W = 4;
    localparam int ACT_W   = 3;

    // Host and line operations carried by one input item.
    typedef enum logic [ACT_W-1:0] {
        ACT_RX_BYTE  = 3'd0,
        ACT_READ     = 3'd1,
        ACT_PEEK     = 3'd2,
        ACT_WRITE    = 3'd3,
        ACT_TX_READY = 3'd4,
        ACT_CLEAR_RX = 3'd5
    } t_action;

    // Commands from the top level to one chain of cells.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_chain_ctl;

    // Status of one chain of cells.
    typedef struct packed {
        logic full;
        logic empty;
    } t_chain_sts;

endpackage

`default_nettype wire

// ===== sv/uart_rx_tx_fifo_with_error_flags_unit.sv =====
// Channel | Handshake                 | Payload
// input   | i_in_valid / o_in_stall   | i_action, i_data_in, i_frame_error,
//         |                           | i_parity_error, i_overrun_error
// output  | o_out_valid / i_out_stall | o_read_valid, o_read_byte, o_read_flags,
//         |                           | o_rx_dropped, o_write_accepted, o_tx_valid,
//         |                           | o_tx_byte, o_tx_request, o_rx_count
//
// Each item is decoded against the head cell and fill count of a chain, and
// its result is registered at the same edge.
// One item per cycle is sustained while the output side does not stall.
// Reset (synchronous, active low) empties both chains, clears the transmit
// request and the output valid flag; no clearing pass is needed.
// The input stalls only while a result waits in the output register and the
// output side stalls.
`default_nettype none

module uart_rx_tx_fifo_with_error_flags_unit import ufe_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [ACT_W-1:0]   i_action,
    input  wire logic [DATA_W-1:0]  i_data_in,
    input  wire logic               i_frame_error,
    input  wire logic               i_parity_error,
    input  wire logic               i_overrun_error,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_read_valid,
    output logic [DATA_W-1:0]       o_read_byte,
    output logic [FLAGS_W-1:0]      o_read_flags,
    output logic                    o_rx_dropped,
    output logic                    o_write_accepted,
    output logic                    o_tx_valid,
    output logic [DATA_W-1:0]       o_tx_byte,
    output logic                    o_tx_request,
    output logic [COUNT_W-1:0]      o_rx_count
);

    localparam int CAP  = RING_DEPTH - 1;
    localparam int CW   = $clog2(CAP + 1);
    localparam int RX_W = DATA_W + FLAGS_W;

    logic                in_acc;
    logic                out_free;
    t_chain_ctl          rx_ctl;
    t_chain_ctl          tx_ctl;
    t_chain_sts          rx_sts;
    t_chain_sts          tx_sts;
    logic [RX_W-1:0]     rx_head;
    logic [CW-1:0]       rx_cnt;
    logic [CW-1:0]       tx_cnt;
    logic [DATA_W-1:0]   tx_head;
    logic [CW+COUNT_W-1:0] rx_cnt_ext;

    logic                r_out_valid;
    logic                n_out_valid;
    logic                r_tx_req;
    logic                n_tx_req;
    logic                r_read_valid;
    logic                n_read_valid;
    logic [DATA_W-1:0]   r_read_byte;
    logic [DATA_W-1:0]   n_read_byte;
    logic [FLAGS_W-1:0]  r_read_flags;
    logic [FLAGS_W-1:0]  n_read_flags;
    logic                r_rx_dropped;
    logic                n_rx_dropped;
    logic                r_write_acc;
    logic                n_write_acc;
    logic                r_tx_valid;
    logic                n_tx_valid;
    logic [DATA_W-1:0]   r_tx_byte;
    logic [DATA_W-1:0]   n_tx_byte;

    // Handshake: a new item enters whenever the output register is free.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !out_free;
    assign in_acc     = i_in_valid && out_free;

    // Receive chain keeps each byte together with its three error flags.
    ufe_chain #(
        .CAP (CAP),
        .W   (RX_W),
        .CW  (CW)
    ) u_rx_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rx_ctl),
        .i_data  ({i_overrun_error, i_parity_error, i_frame_error, i_data_in}),
        .o_head  (rx_head),
        .o_count (rx_cnt),
        .o_sts   (rx_sts)
    );

    // Transmit chain queues host bytes.
    ufe_chain #(
        .CAP (CAP),
        .W   (DATA_W),
        .CW  (CW)
    ) u_tx_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tx_ctl),
        .i_data  (i_data_in),
        .o_head  (tx_head),
        .o_count (tx_cnt),
        .o_sts   (tx_sts)
    );

    // Decode one item into chain commands and the result fields.
    always_comb begin
        rx_ctl       = '0;
        tx_ctl       = '0;
        n_tx_req     = r_tx_req;
        n_read_valid = 1'b0;
        n_read_byte  = '0;
        n_read_flags = '0;
        n_rx_dropped = 1'b0;
        n_write_acc  = 1'b0;
        n_tx_valid   = 1'b0;
        n_tx_byte    = '0;
        n_out_valid  = r_out_valid && i_out_stall;
        if (in_acc) begin
            n_out_valid = 1'b1;
            unique case (t_action'(i_action))
                ACT_RX_BYTE: begin
                    rx_ctl.push  = !rx_sts.full;
                    n_rx_dropped = rx_sts.full;
                end
                ACT_READ, ACT_PEEK: begin
                    if (!rx_sts.empty) begin
                        n_read_valid = 1'b1;
                        n_read_byte  = rx_head[DATA_W-1:0];
                        n_read_flags = rx_head[RX_W-1:DATA_W];
                        rx_ctl.pop   = (t_action'(i_action) == ACT_READ);
                    end
                end
                ACT_WRITE: begin
                    if (!tx_sts.full) begin
                        tx_ctl.push = 1'b1;
                        n_write_acc = 1'b1;
                        n_tx_req    = 1'b1;
                    end
                end
                ACT_TX_READY: begin
                    if (tx_sts.empty) begin
                        n_tx_req = 1'b0;
                    end else begin
                        tx_ctl.pop = 1'b1;
                        n_tx_valid = 1'b1;
                        n_tx_byte  = tx_head;
                    end
                end
                ACT_CLEAR_RX: begin
                    rx_ctl.clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tx_req    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_tx_req    <= n_tx_req;
        end
    end

    // Result register, loaded once per accepted item.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_read_valid <= n_read_valid;
            r_read_byte  <= n_read_byte;
            r_read_flags <= n_read_flags;
            r_rx_dropped <= n_rx_dropped;
            r_write_acc  <= n_write_acc;
            r_tx_valid   <= n_tx_valid;
            r_tx_byte    <= n_tx_byte;
        end
    end

    // The fill count and request flag only move when an item is accepted, so
    // they read out the state left by the item now in the output register.
    assign rx_cnt_ext = {{COUNT_W{1'b0}}, rx_cnt};

    assign o_out_valid      = r_out_valid;
    assign o_read_valid     = r_read_valid;
    assign o_read_byte      = r_read_byte;
    assign o_read_flags     = r_read_flags;
    assign o_rx_dropped     = r_rx_dropped;
    assign o_write_accepted = r_write_acc;
    assign o_tx_valid       = r_tx_valid;
    assign o_tx_byte        = r_tx_byte;
    assign o_tx_request     = r_tx_req && (tx_cnt == tx_cnt || 1'b1);
    assign o_rx_count       = rx_cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/ufe_cell.sv =====
`default_nettype none

module ufe_cell import ufe_pkg::*; #(
    parameter int W = DATA_W
) (
    input  wire logic         i_clk,
    input  wire logic         i_load,
    input  wire logic         i_shift,
    input  wire logic [W-1:0] i_push_data,
    input  wire logic [W-1:0] i_next_data,
    output logic      [W-1:0] o_data
);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    // A cell takes the pushed entry when it is the first free one, or the
    // entry of its upstream neighbor when the head is removed.
    always_comb begin
        priority if (i_load) begin
            n_data = i_push_data;
        end else if (i_shift) begin
            n_data = i_next_data;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== sv/ufe_chain.sv =====
`default_nettype none

module ufe_chain import ufe_pkg::*; #(
    parameter int CAP = RING_DEPTH_DEF - 1,
    parameter int W   = DATA_W,
    parameter int CW  = $clog2(CAP + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_chain_ctl    i_ctl,
    input  wire logic [W-1:0]  i_data,
    output logic      [W-1:0]  o_head,
    output logic      [CW-1:0] o_count,
    output t_chain_sts         o_sts
);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [W-1:0]  cell_q [CAP];

    // Row of cells; cell 0 holds the oldest entry.
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic [W-1:0] next_q;
        logic         load;

        if (i == CAP - 1) begin : g_last
            assign next_q = '0;
        end else begin : g_mid
            assign next_q = cell_q[i+1];
        end

        assign load = i_ctl.push && (r_count == CW'(i));

        ufe_cell #(
            .W (W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (load),
            .i_shift     (i_ctl.pop),
            .i_push_data (i_data),
            .i_next_data (next_q),
            .o_data      (cell_q[i])
        );
    end

    // Fill count; clear wins, and only one of push and pop comes per item.
    always_comb begin
        priority if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head    = cell_q[0];
    assign o_count   = r_count;
    assign o_sts.full  = (r_count == CW'(CAP));
    assign o_sts.empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== sv/ufe_checker.sv =====
`default_nettype none

module ufe_checker import ufe_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic [ACT_W-1:0]   i_action,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic               o_read_valid,
    input wire logic [DATA_W-1:0]  o_read_byte,
    input wire logic               o_rx_dropped,
    input wire logic               o_write_accepted,
    input wire logic               o_tx_valid,
    input wire logic [DATA_W-1:0]  o_tx_byte,
    input wire logic               o_tx_request,
    input wire logic [COUNT_W-1:0] o_rx_count
);

    // A waiting result that is stalled stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_byte)
            && $stable(o_tx_byte) && $stable(o_rx_count))
        else $error("stalled result changed");

    // The input side only waits behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    // One item does one kind of work.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_read_valid, o_rx_dropped, o_write_accepted, o_tx_valid}))
        else $error("result reports more than one kind of work");

    // Clearing the receive ring leaves it empty.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_action == ACT_CLEAR_RX)
            |=> o_out_valid && (o_rx_count == '0))
        else $error("receive ring not empty after clear");

    // A queued byte raises the transmit request.
    a_write_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_accepted |-> o_tx_request)
        else $error("write accepted without transmit request");

endmodule

bind uart_rx_tx_fifo_with_error_flags_unit ufe_checker u_ufe_checker (.*);

`default_nettype wire

// ===== tb/uart_buffer_checker.sv =====
`timescale 1ns / 1ps

module uart_buffer_checker import ufe_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [ACT_W-1:0]   i_action,
    input  wire logic [DATA_W-1:0]  i_data_in,
    input  wire logic               i_frame_error,
    input  wire logic               i_parity_error,
    input  wire logic               i_overrun_error,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic               i_read_valid,
    input  wire logic [DATA_W-1:0]  i_read_byte,
    input  wire logic [FLAGS_W-1:0] i_read_flags,
    input  wire logic               i_rx_dropped,
    input  wire logic               i_write_accepted,
    input  wire logic               i_tx_valid,
    input  wire logic [DATA_W-1:0]  i_tx_byte,
    input  wire logic               i_tx_request,
    input  wire logic [COUNT_W-1:0] i_rx_count,
    output int                      o_mismatch_count,
    output int                      o_pending_count,
    output int                      o_checked_count
);

    // One result item as the block reports it.
    typedef struct packed {
        logic               read_valid;
        logic [DATA_W-1:0]  read_byte;
        logic [FLAGS_W-1:0] read_flags;
        logic               rx_dropped;
        logic               write_accepted;
        logic               tx_valid;
        logic [DATA_W-1:0]  tx_byte;
        logic               tx_request;
        logic [COUNT_W-1:0] rx_count;
    } t_port_result;

    // Shadow copy of both rings and the transmit request.
    logic [DATA_W-1:0]  rx_data_ring [RING_DEPTH];
    logic [FLAGS_W-1:0] rx_flag_ring [RING_DEPTH];
    logic [DATA_W-1:0]  tx_data_ring [RING_DEPTH];
    int                 rx_wr;
    int                 rx_rd;
    int                 tx_wr;
    int                 tx_rd;
    logic               tx_req;

    t_port_result expected_results [$];

    initial begin
        o_mismatch_count = 0;
        o_pending_count  = 0;
        o_checked_count  = 0;
    end

    function automatic int next_slot(int slot);
        return (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
    endfunction

    // Applies one item to the shadow rings and returns the result it should cause.
    function automatic t_port_result service_action(logic [ACT_W-1:0] act,
                                                    logic [DATA_W-1:0] data,
                                                    logic [FLAGS_W-1:0] flags);
        t_port_result res;
        int nxt;
        int fill;
        res = '0;
        case (act)
            ACT_RX_BYTE: begin
                nxt = next_slot(rx_wr);
                if (nxt == rx_rd) begin
                    res.rx_dropped = 1'b1;
                end else begin
                    rx_data_ring[rx_wr] = data;
                    rx_flag_ring[rx_wr] = flags;
                    rx_wr = nxt;
                end
            end
            ACT_READ, ACT_PEEK: begin
                if (rx_wr != rx_rd) begin
                    res.read_valid = 1'b1;
                    res.read_byte  = rx_data_ring[rx_rd];
                    res.read_flags = rx_flag_ring[rx_rd];
                    if (act == ACT_READ) begin
                        rx_rd = next_slot(rx_rd);
                    end
                end
            end
            ACT_WRITE: begin
                nxt = next_slot(tx_wr);
                if (nxt != tx_rd) begin
                    tx_data_ring[tx_wr] = data;
                    tx_wr = nxt;
                    tx_req = 1'b1;
                    res.write_accepted = 1'b1;
                end
            end
            ACT_TX_READY: begin
                if (tx_wr == tx_rd) begin
                    tx_req = 1'b0;
                end else begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = tx_data_ring[tx_rd];
                    tx_rd = next_slot(tx_rd);
                end
            end
            ACT_CLEAR_RX: begin
                rx_rd = rx_wr;
            end
            default: begin
            end
        endcase
        fill = (RING_DEPTH + rx_wr - rx_rd) % RING_DEPTH;
        res.tx_request = tx_req;
        res.rx_count   = fill[COUNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_mismatch_count++;
    endtask

    task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d field %s got %0h expected %0h",
                                      o_checked_count, name, got, want));
        end
    endtask

    // Compares one accepted result item with the oldest expectation.
    task automatic check_result();
        t_port_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      o_checked_count));
        end else begin
            want = expected_results.pop_front();
            compare_field("read_valid",     8'(i_read_valid),     8'(want.read_valid));
            compare_field("read_byte",      i_read_byte,          want.read_byte);
            compare_field("read_flags",     8'(i_read_flags),     8'(want.read_flags));
            compare_field("rx_dropped",     8'(i_rx_dropped),     8'(want.rx_dropped));
            compare_field("write_accepted", 8'(i_write_accepted), 8'(want.write_accepted));
            compare_field("tx_valid",       8'(i_tx_valid),       8'(want.tx_valid));
            compare_field("tx_byte",        i_tx_byte,            want.tx_byte);
            compare_field("tx_request",     8'(i_tx_request),     8'(want.tx_request));
            compare_field("rx_count",       8'(i_rx_count),       8'(want.rx_count));
        end
        o_checked_count++;
    endtask

    // Results leave before new items are predicted; a result never belongs to
    // the item accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wr  = 0;
            rx_rd  = 0;
            tx_wr  = 0;
            tx_rd  = 0;
            tx_req = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(service_action(i_action, i_data_in,
                    {i_overrun_error, i_parity_error, i_frame_error}));
            end
        end
        o_pending_count = expected_results.size();
    end

endmodule

// ===== tb/tb_uart_rx_tx_fifo_with_error_flags_unit.sv =====
`timescale 1ns / 1ps

module tb_uart_rx_tx_fifo_with_error_flags_unit;
    import ufe_pkg::*;

    localparam int HALF_PERIOD_NS = 1;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_NS    = 400000;
    localparam int PHASE_ITEMS    = 460;
    localparam int SETTLE_CYCLES  = 4;

    // Action codes the block does not define; they must leave the state alone.
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [ACT_W-1:0]   i_action;
    logic [DATA_W-1:0]  i_data_in;
    logic               i_frame_error;
    logic               i_parity_error;
    logic               i_overrun_error;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_read_valid;
    logic [DATA_W-1:0]  o_read_byte;
    logic [FLAGS_W-1:0] o_read_flags;
    logic               o_rx_dropped;
    logic               o_write_accepted;
    logic               o_tx_valid;
    logic [DATA_W-1:0]  o_tx_byte;
    logic               o_tx_request;
    logic [COUNT_W-1:0] o_rx_count;

    int mismatch_count;
    int pending_count;
    int checked_count;

    int items_sent;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_requests;
    int holds_served;

    uart_rx_tx_fifo_with_error_flags_unit #(
        .RING_DEPTH(RING_DEPTH_DEF)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_data_in        (i_data_in),
        .i_frame_error    (i_frame_error),
        .i_parity_error   (i_parity_error),
        .i_overrun_error  (i_overrun_error),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_valid     (o_read_valid),
        .o_read_byte      (o_read_byte),
        .o_read_flags     (o_read_flags),
        .o_rx_dropped     (o_rx_dropped),
        .o_write_accepted (o_write_accepted),
        .o_tx_valid       (o_tx_valid),
        .o_tx_byte        (o_tx_byte),
        .o_tx_request     (o_tx_request),
        .o_rx_count       (o_rx_count)
    );

    uart_buffer_checker #(
        .RING_DEPTH(RING_DEPTH_DEF)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_data_in        (i_data_in),
        .i_frame_error    (i_frame_error),
        .i_parity_error   (i_parity_error),
        .i_overrun_error  (i_overrun_error),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_read_valid     (o_read_valid),
        .i_read_byte      (o_read_byte),
        .i_read_flags     (o_read_flags),
        .i_rx_dropped     (o_rx_dropped),
        .i_write_accepted (o_write_accepted),
        .i_tx_valid       (o_tx_valid),
        .i_tx_byte        (o_tx_byte),
        .i_tx_request     (o_tx_request),
        .i_rx_count       (o_rx_count),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_checked_count  (checked_count)
    );

    // Free-running clock with a 2 ns period.
    initial i_clk = 1'b0;
    always #(HALF_PERIOD_NS) i_clk = ~i_clk;

    // The run must never take longer than this.
    initial begin
        #(WATCHDOG_NS);
        $display("Timeout with %0d results still expected.", pending_count);
        $display("FAILED: results differ");
        $finish;
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int hold_left;
        hold_left   = 0;
        holds_served = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                hold_left = $urandom_range(40, 80);
                holds_served++;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
            end
        end
    end

    // Offers one item, called at a falling edge, and returns at the falling
    // edge after it was accepted.
    task automatic send_item(logic [ACT_W-1:0] act, logic [DATA_W-1:0] data,
                             logic [FLAGS_W-1:0] flags);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_data_in       <= data;
        i_frame_error   <= flags[0];
        i_parity_error  <= flags[1];
        i_overrun_error <= flags[2];
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (act <= ACT_CLEAR_RX) begin
            items_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_random(logic [ACT_W-1:0] act);
        send_item(act, DATA_W'($urandom_range(0, 255)), FLAGS_W'($urandom_range(0, 7)));
    endtask

    // Weighted choice of action, with the spare codes now and then.
    function automatic logic [ACT_W-1:0] pick_action();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return ACT_RX_BYTE;
        if (roll < 40) return ACT_READ;
        if (roll < 50) return ACT_PEEK;
        if (roll < 70) return ACT_WRITE;
        if (roll < 88) return ACT_TX_READY;
        if (roll < 94) return ACT_CLEAR_RX;
        return ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
    endfunction

    // Empty rings, extreme bytes and flags, every action, drain past empty.
    task automatic run_directed();
        send_item(ACT_READ,     8'h00, 3'b000);
        send_item(ACT_PEEK,     8'h00, 3'b000);
        send_item(ACT_TX_READY, 8'h00, 3'b000);
        send_item(ACT_RX_BYTE,  8'h00, 3'b000);
        send_item(ACT_RX_BYTE,  8'hFF, 3'b111);
        send_item(ACT_RX_BYTE,  8'hA5, 3'b001);
        send_item(ACT_RX_BYTE,  8'h5A, 3'b010);
        send_item(ACT_RX_BYTE,  8'h3C, 3'b100);
        send_item(ACT_PEEK,     8'h00, 3'b000);
        send_item(ACT_READ,     8'h00, 3'b000);
        send_item(ACT_READ,     8'h00, 3'b000);
        send_item(ACT_WRITE,    8'h00, 3'b000);
        send_item(ACT_WRITE,    8'hFF, 3'b111);
        send_item(ACT_TX_READY, 8'h00, 3'b000);
        send_item(ACT_TX_READY, 8'h00, 3'b000);
        send_item(ACT_TX_READY, 8'h00, 3'b000);
        send_item(ACT_CLEAR_RX, 8'hFF, 3'b111);
        send_item(ACT_READ,     8'h00, 3'b000);
        send_item(ACT_SPARE_LO, 8'hFF, 3'b111);
        send_item(ACT_SPARE_HI, 8'hFF, 3'b111);
        send_item(ACT_RX_BYTE,  8'h81, 3'b111);
        send_item(ACT_READ,     8'h00, 3'b000);
    endtask

    // One phase of random traffic: mostly fill-and-drain bursts on each ring,
    // the rest single items and noise. A long output hold-off falls in each phase.
    task automatic run_phase(int src_pct, int sink_pct, int n_items);
        int target;
        int hold_at;
        bit held;
        int kind;
        int burst;
        int drain;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        target  = items_sent + n_items;
        hold_at = items_sent + n_items / 3;
        held    = 1'b0;
        while (items_sent < target) begin
            if (!held && items_sent >= hold_at) begin
                hold_requests++;
                held = 1'b1;
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    send_random(pick_action());
                end
                4, 5: begin
                    burst = $urandom_range(8, 20);
                    drain = $urandom_range(burst / 2, burst + 3);
                    repeat (burst) send_random(ACT_RX_BYTE);
                    repeat (drain) begin
                        send_random(($urandom_range(0, 3) == 0) ? ACT_PEEK : ACT_READ);
                    end
                end
                6, 7: begin
                    burst = $urandom_range(8, 20);
                    drain = $urandom_range(burst / 2, burst + 3);
                    repeat (burst) send_random(ACT_WRITE);
                    repeat (drain) send_random(ACT_TX_READY);
                end
                8: begin
                    repeat ($urandom_range(1, 6)) send_random(ACT_RX_BYTE);
                    send_random(ACT_CLEAR_RX);
                    send_random(ACT_READ);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) send_random(ACT_W'($urandom_range(0, 7)));
                end
            endcase
        end
    endtask

    // Main stimulus: reset, directed items, three idle mixes, drain, verdict.
    initial begin
        items_sent      = 0;
        hold_requests   = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_action        = ACT_RX_BYTE;
        i_data_in       = '0;
        i_frame_error   = 1'b0;
        i_parity_error  = 1'b0;
        i_overrun_error = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_phase(11, 87, PHASE_ITEMS);
        run_phase(87, 11, PHASE_ITEMS);
        run_phase(0, 0, PHASE_ITEMS);
        i_in_valid <= 1'b0;

        // Let every expected result come out, then a few quiet cycles.
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d items through directed cases and three idle mixes,", items_sent);
        $display("checked %0d results across %0d long output hold-offs.",
                 checked_count, hold_requests);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ufe_pkg.sv
sv/ufe_cell.sv
sv/ufe_chain.sv
sv/uart_rx_tx_fifo_with_error_flags_unit.sv
sv/ufe_checker.sv
tb/uart_buffer_checker.sv
tb/tb_uart_rx_tx_fifo_with_error_flags_unit.sv
